>>> rtl/hsvrt_pkg.sv
`timescale 1ns / 1ps

package hsvrt_pkg;

   // one input pixel
   typedef struct packed {
      logic [7:0] blue;
      logic [7:0] green;
      logic [7:0] red;
      logic       frame_end;
   } req_type;

   // one threshold result
   typedef struct packed {
      logic [7:0] mask;
      logic       frame_end_out;
   } rsp_type;

   // configuration register map
   localparam int NUM_CSR     = 6;
   localparam int CSR_INDEX_W = 3;

   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_HUE_LOW  = 3'd0,
      REG_HUE_HIGH = 3'd1,
      REG_SAT_LOW  = 3'd2,
      REG_SAT_HIGH = 3'd3,
      REG_VAL_LOW  = 3'd4,
      REG_VAL_HIGH = 3'd5
   } csr_index_type;

   localparam logic [7:0] CSR_RESET [NUM_CSR] = '{8'd0, 8'd60, 8'd80, 8'd255, 8'd70, 8'd255};

   // hue sector offsets in half-degrees
   localparam logic [6:0] HUE_OFS_RED   = 7'd0;
   localparam logic [6:0] HUE_OFS_GREEN = 7'd60;
   localparam logic [6:0] HUE_OFS_BLUE  = 7'd120;
   localparam logic [8:0] HUE_WRAP      = 9'd180;

   // largest hue quotient round(30*delta/range)
   localparam logic [4:0] HUE_Q_MAX = 5'd30;

   localparam logic [7:0] MASK_ON  = 8'hFF;
   localparam logic [7:0] MASK_OFF = 8'h00;

   // divider layout: two quotient bits per stage
   localparam int DIV_STAGES = 4;
   localparam int SAT_Q_W    = 8;
   localparam int HUE_Q_W    = 5;

   // front stage: max, min, range and sector
   typedef struct packed {
      logic       frame_end;
      logic [7:0] v;
      logic [7:0] d;
      logic [7:0] mag;
      logic       neg;
      logic [6:0] offset;
   } front_type;

   // divider stage payload
   typedef struct packed {
      logic         frame_end;
      logic [7:0]   v;
      logic         gray;
      logic         black;
      logic         neg;
      logic [6:0]   offset;
      logic [16:0]  rem_s;
      logic [8:0]   div_s;
      logic [SAT_Q_W-1:0] q_s;
      logic [13:0]  rem_h;
      logic [8:0]   div_h;
      logic [HUE_Q_W-1:0] q_h;
   } stage_type;

endpackage

>>> rtl/hsv_range_threshold.sv
`timescale 1ns / 1ps

// Color threshold on one BGR pixel per clock. Each pixel is converted to 8-bit
// HSV (hue in half-degrees 0..179, saturation and value 0..255, divisions rounded
// half away from zero) and the result mask is 255 when all three lie inside the
// inclusive bounds held in the six configuration registers, else 0. busy never
// rises: a pixel can be started in every cycle. Its result is shown on rsp_*
// with rsp_valid for one cycle, after passing one sorting stage, one
// numerator stage, four divider stages of two quotient bits each and one
// compare stage. The receiver must take every result in the cycle it is shown;
// there is no back-pressure. Configuration writes are always taken and should
// be made while no pixel is in flight.
module hsv_range_threshold (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  hsvrt_pkg::req_type                  req_data,
   output logic                                rsp_valid,
   output hsvrt_pkg::rsp_type                  rsp_data,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [hsvrt_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [7:0]                          csr_data
);

   logic [7:0] cfg_ff [hsvrt_pkg::NUM_CSR];

   logic                  front_valid_ff;
   hsvrt_pkg::front_type  front_ff, front_in;

   logic                  valid_ff [0:hsvrt_pkg::DIV_STAGES];
   hsvrt_pkg::stage_type  pipe_ff  [0:hsvrt_pkg::DIV_STAGES];
   hsvrt_pkg::stage_type  num_in;
   hsvrt_pkg::stage_type  pipe_in  [1:hsvrt_pkg::DIV_STAGES];

   logic                  rsp_valid_ff;
   hsvrt_pkg::rsp_type    rsp_data_ff, rsp_data_in;

   assign busy      = 1'b0;
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // write configuration registers, ignore indexes past the map
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < hsvrt_pkg::NUM_CSR; i++) begin
            cfg_ff[i] <= hsvrt_pkg::CSR_RESET[i];
         end
      end else if (csr_valid && (32'(csr_index) < hsvrt_pkg::NUM_CSR)) begin
         cfg_ff[csr_index] <= csr_data;
      end
   end

   // sort channels: max, min, range and signed hue delta
   always_comb begin
      logic [7:0] b, g, r, mx, mn;
      logic [8:0] diff;
      b = req_data.blue;
      g = req_data.green;
      r = req_data.red;
      mx = r;
      if (g > mx) mx = g;
      if (b > mx) mx = b;
      mn = r;
      if (g < mn) mn = g;
      if (b < mn) mn = b;
      if (mx == r) begin
         diff            = {1'b0, g} - {1'b0, b};
         front_in.offset = hsvrt_pkg::HUE_OFS_RED;
      end else if (mx == g) begin
         diff            = {1'b0, b} - {1'b0, r};
         front_in.offset = hsvrt_pkg::HUE_OFS_GREEN;
      end else begin
         diff            = {1'b0, r} - {1'b0, g};
         front_in.offset = hsvrt_pkg::HUE_OFS_BLUE;
      end
      front_in.frame_end = req_data.frame_end;
      front_in.v         = mx;
      front_in.d         = mx - mn;
      front_in.neg       = diff[8];
      front_in.mag       = diff[8] ? 8'(-diff) : diff[7:0];
   end

   // form rounded numerators and doubled divisors
   always_comb begin
      num_in.frame_end = front_ff.frame_end;
      num_in.v         = front_ff.v;
      num_in.gray      = (front_ff.d == 8'd0);
      num_in.black     = (front_ff.v == 8'd0);
      num_in.neg       = front_ff.neg;
      num_in.offset    = front_ff.offset;
      // 510*d + v
      num_in.rem_s     = {front_ff.d, 9'd0} - {8'd0, front_ff.d, 1'b0}
                         + {9'd0, front_ff.v};
      num_in.div_s     = {front_ff.v, 1'b0};
      num_in.q_s       = '0;
      // 60*mag + d
      num_in.rem_h     = {front_ff.mag, 6'd0} - {4'd0, front_ff.mag, 2'd0}
                         + {6'd0, front_ff.d};
      num_in.div_h     = {front_ff.d, 1'b0};
      num_in.q_h       = '0;
   end

   // restoring division, two quotient bits per stage for each divider
   always_comb begin
      logic [16:0] sub_s;
      logic [13:0] sub_h;
      int          bs;
      int          bh;
      sub_s = '0;
      sub_h = '0;
      bs    = 0;
      bh    = 0;
      for (int k = 0; k < hsvrt_pkg::DIV_STAGES; k++) begin
         pipe_in[k+1] = pipe_ff[k];
         for (int j = 0; j < 2; j++) begin
            bs    = hsvrt_pkg::SAT_Q_W - 1 - 2 * k - j;
            sub_s = {8'd0, pipe_in[k+1].div_s} << bs;
            if (pipe_in[k+1].rem_s >= sub_s) begin
               pipe_in[k+1].rem_s   = pipe_in[k+1].rem_s - sub_s;
               pipe_in[k+1].q_s[bs] = 1'b1;
            end
            bh = hsvrt_pkg::HUE_Q_W - 1 - 2 * k - j;
            if (bh >= 0) begin
               sub_h = {5'd0, pipe_in[k+1].div_h} << bh;
               if (pipe_in[k+1].rem_h >= sub_h) begin
                  pipe_in[k+1].rem_h   = pipe_in[k+1].rem_h - sub_h;
                  pipe_in[k+1].q_h[bh] = 1'b1;
               end
            end
         end
      end
   end

   // assemble hue, drop gray and black cases, compare against bounds
   always_comb begin
      hsvrt_pkg::stage_type st;
      logic [8:0]  hs;
      logic [7:0]  hue, sat, val;
      logic        in_bounds;
      st  = pipe_ff[hsvrt_pkg::DIV_STAGES];
      hs  = st.neg ? ({2'd0, st.offset} - {4'd0, st.q_h})
                   : ({2'd0, st.offset} + {4'd0, st.q_h});
      if (hs[8]) hs = hs + hsvrt_pkg::HUE_WRAP;
      hue = st.gray  ? 8'd0 : hs[7:0];
      sat = st.black ? 8'd0 : st.q_s;
      val = st.v;
      in_bounds = (hue >= cfg_ff[hsvrt_pkg::REG_HUE_LOW])
               && (hue <= cfg_ff[hsvrt_pkg::REG_HUE_HIGH])
               && (sat >= cfg_ff[hsvrt_pkg::REG_SAT_LOW])
               && (sat <= cfg_ff[hsvrt_pkg::REG_SAT_HIGH])
               && (val >= cfg_ff[hsvrt_pkg::REG_VAL_LOW])
               && (val <= cfg_ff[hsvrt_pkg::REG_VAL_HIGH]);
      rsp_data_in.mask          = in_bounds ? hsvrt_pkg::MASK_ON : hsvrt_pkg::MASK_OFF;
      rsp_data_in.frame_end_out = st.frame_end;
   end

   // advance valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         front_valid_ff <= 1'b0;
         for (int k = 0; k <= hsvrt_pkg::DIV_STAGES; k++) begin
            valid_ff[k] <= 1'b0;
         end
         rsp_valid_ff <= 1'b0;
      end else begin
         front_valid_ff <= start && !busy;
         valid_ff[0]    <= front_valid_ff;
         for (int k = 1; k <= hsvrt_pkg::DIV_STAGES; k++) begin
            valid_ff[k] <= valid_ff[k-1];
         end
         rsp_valid_ff <= valid_ff[hsvrt_pkg::DIV_STAGES];
      end
   end

   // advance payload
   always_ff @(posedge clock) begin
      front_ff   <= front_in;
      pipe_ff[0] <= num_in;
      for (int k = 1; k <= hsvrt_pkg::DIV_STAGES; k++) begin
         pipe_ff[k] <= pipe_in[k];
      end
      rsp_data_ff <= rsp_data_in;
   end

`ifndef SYNTH
   a_latency : assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##7 rsp_valid)
      else $error("started item did not come out after seven edges");

   a_frame_end : assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_data.frame_end) |-> ##7 rsp_data.frame_end_out)
      else $error("frame end marker lost in the pipeline");

   a_hue_quot : assert property (@(posedge clock) disable iff (reset)
      (valid_ff[hsvrt_pkg::DIV_STAGES] && !pipe_ff[hsvrt_pkg::DIV_STAGES].gray)
      |-> (pipe_ff[hsvrt_pkg::DIV_STAGES].q_h <= hsvrt_pkg::HUE_Q_MAX))
      else $error("hue quotient out of range");

   a_black_gray : assert property (@(posedge clock) disable iff (reset)
      (valid_ff[hsvrt_pkg::DIV_STAGES] && pipe_ff[hsvrt_pkg::DIV_STAGES].black)
      |-> pipe_ff[hsvrt_pkg::DIV_STAGES].gray)
      else $error("black pixel not flagged gray");

   a_mask_code : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.mask == hsvrt_pkg::MASK_ON
                     || rsp_data.mask == hsvrt_pkg::MASK_OFF))
      else $error("mask holds a value other than on or off");
`endif

endmodule

>>> test/hsv_range_threshold_tb.sv
`timescale 1ns / 1ps

module hsv_range_threshold_tb;

   localparam int PIPE_LAT     = 7;
   localparam int DRAIN_CYCLES = PIPE_LAT + 4;
   localparam int STALL_LIMIT  = 2000;
   localparam int FIXED_ITEMS  = 150;
   localparam int RAND_PHASES  = 10;
   localparam int RAND_ITEMS   = 113;
   localparam int HUE_TOP      = 179;

   // expected masks for pixels in flight, with a private copy of the bounds
   class hsv_mask_scoreboard;
      logic [7:0]          bound [hsvrt_pkg::NUM_CSR];
      hsvrt_pkg::rsp_type  mask_queue [$];
      int unsigned         mismatches;

      function new();
         foreach (bound[i]) bound[i] = hsvrt_pkg::CSR_RESET[i];
         mismatches = 0;
      endfunction

      function void write_bound(logic [hsvrt_pkg::CSR_INDEX_W-1:0] idx, logic [7:0] val);
         // indexes past the register map are dropped
         if (idx < hsvrt_pkg::NUM_CSR) bound[idx] = val;
      endfunction

      // round(30*x/d), half away from zero
      function int hue_term(int x, int d);
         int q;
         q = (60 * ((x < 0) ? -x : x) + d) / (2 * d);
         return (x < 0) ? -q : q;
      endfunction

      function hsvrt_pkg::rsp_type threshold(hsvrt_pkg::req_type px);
         int                  b, g, r, v, mn, d, h, s;
         bit                  in_range;
         hsvrt_pkg::rsp_type  res;
         b = int'(px.blue);
         g = int'(px.green);
         r = int'(px.red);
         v = r;
         if (g > v) v = g;
         if (b > v) v = b;
         mn = r;
         if (g < mn) mn = g;
         if (b < mn) mn = b;
         d = v - mn;
         s = (v == 0) ? 0 : (510 * d + v) / (2 * v);
         // red wins ties over green, green over blue
         if (d == 0) h = 0;
         else if (v == r) h = hue_term(g - b, d);
         else if (v == g) h = 60 + hue_term(b - r, d);
         else h = 120 + hue_term(r - g, d);
         if (h < 0) h += 180;
         in_range = h >= int'(bound[hsvrt_pkg::REG_HUE_LOW])
                 && h <= int'(bound[hsvrt_pkg::REG_HUE_HIGH])
                 && s >= int'(bound[hsvrt_pkg::REG_SAT_LOW])
                 && s <= int'(bound[hsvrt_pkg::REG_SAT_HIGH])
                 && v >= int'(bound[hsvrt_pkg::REG_VAL_LOW])
                 && v <= int'(bound[hsvrt_pkg::REG_VAL_HIGH]);
         res.mask          = in_range ? hsvrt_pkg::MASK_ON : hsvrt_pkg::MASK_OFF;
         res.frame_end_out = px.frame_end;
         return res;
      endfunction

      function void note_pixel(hsvrt_pkg::req_type px);
         mask_queue.push_back(threshold(px));
      endfunction

      function void check_result(hsvrt_pkg::rsp_type got);
         hsvrt_pkg::rsp_type want;
         if (mask_queue.size() == 0) begin
            $error("result with no pixel pending: mask %0d frame_end_out %0d",
                   got.mask, got.frame_end_out);
            mismatches++;
            return;
         end
         want = mask_queue.pop_front();
         if (got.mask !== want.mask) begin
            $error("mask: expected %0d, got %0d", want.mask, got.mask);
            mismatches++;
         end
         if (got.frame_end_out !== want.frame_end_out) begin
            $error("frame_end_out: expected %0d, got %0d",
                   want.frame_end_out, got.frame_end_out);
            mismatches++;
         end
      endfunction

      function int pending();
         return mask_queue.size();
      endfunction
   endclass

   logic                              clock;
   logic                              reset     = 1'b1;
   logic                              start     = 1'b0;
   logic                              busy;
   hsvrt_pkg::req_type                req_data  = '0;
   logic                              rsp_valid;
   hsvrt_pkg::rsp_type                rsp_data;
   logic                              csr_valid = 1'b0;
   logic                              csr_ready;
   logic [hsvrt_pkg::CSR_INDEX_W-1:0] csr_index = '0;
   logic [7:0]                        csr_data  = '0;

   hsv_mask_scoreboard sb = new();
   int                 stall_cycles = 0;

   hsv_range_threshold dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // watch both channels and the register port at each rising edge
   always @(posedge clock) begin
      if (reset) begin
         stall_cycles = 0;
      end else begin
         stall_cycles = stall_cycles + 1;
         if (start && !busy) begin
            sb.note_pixel(req_data);
            stall_cycles = 0;
         end
         if (rsp_valid) begin
            sb.check_result(rsp_data);
            stall_cycles = 0;
         end
         if (csr_valid && csr_ready) begin
            sb.write_bound(csr_index, csr_data);
            stall_cycles = 0;
         end
      end
   end

   // end the run if nothing moves for too long
   initial begin
      while (stall_cycles < STALL_LIMIT) @(negedge clock);
      $display("Verification failed");
      $finish;
   end

   function automatic hsvrt_pkg::req_type make_pixel(int b, int g, int r, bit fe);
      hsvrt_pkg::req_type px;
      px.blue      = b[7:0];
      px.green     = g[7:0];
      px.red       = r[7:0];
      px.frame_end = fe;
      return px;
   endfunction

   // uniform pixels, plus greys, channel ties, extremes and dark ones
   function automatic hsvrt_pkg::req_type random_pixel();
      hsvrt_pkg::req_type px;
      logic [7:0]         corner [4] = '{8'd0, 8'd1, 8'd254, 8'd255};
      px.blue      = 8'($urandom);
      px.green     = 8'($urandom);
      px.red       = 8'($urandom);
      px.frame_end = ($urandom_range(0, 15) == 0);
      case ($urandom_range(0, 10))
         5: begin
            px.green = px.blue;
            px.red   = px.blue;
         end
         6: px.green = px.red;
         7: px.blue = px.red;
         8: px.blue = px.green;
         9: begin
            px.blue  = corner[$urandom_range(0, 3)];
            px.green = corner[$urandom_range(0, 3)];
            px.red   = corner[$urandom_range(0, 3)];
         end
         10: begin
            px.blue  = 8'($urandom_range(0, 7));
            px.green = 8'($urandom_range(0, 7));
            px.red   = 8'($urandom_range(0, 7));
         end
         default: ;
      endcase
      return px;
   endfunction

   // hold one pixel on the port until it is taken
   task automatic send_pixel(hsvrt_pkg::req_type px);
      @(negedge clock);
      start    = 1'b1;
      req_data = px;
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   task automatic idle_cycles(int n);
      repeat (n) begin
         @(negedge clock);
         start    = 1'b0;
         req_data = random_pixel();
      end
   endtask

   // drop start and wait out every pixel in flight
   task automatic hold_until_drained();
      @(negedge clock);
      start = 1'b0;
      while (sb.pending() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_csr(logic [hsvrt_pkg::CSR_INDEX_W-1:0] idx, logic [7:0] val);
      @(negedge clock);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_data  = val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
   endtask

   // program all six bounds, then poke the unused indexes with noise
   task automatic set_bounds(int hl, int hh, int sl, int sh, int vl, int vh);
      write_csr(hsvrt_pkg::REG_HUE_LOW,  hl[7:0]);
      write_csr(hsvrt_pkg::REG_HUE_HIGH, hh[7:0]);
      write_csr(hsvrt_pkg::REG_SAT_LOW,  sl[7:0]);
      write_csr(hsvrt_pkg::REG_SAT_HIGH, sh[7:0]);
      write_csr(hsvrt_pkg::REG_VAL_LOW,  vl[7:0]);
      write_csr(hsvrt_pkg::REG_VAL_HIGH, vh[7:0]);
      for (int idx = hsvrt_pkg::NUM_CSR; idx < (1 << hsvrt_pkg::CSR_INDEX_W); idx++)
         write_csr(idx[hsvrt_pkg::CSR_INDEX_W-1:0], 8'($urandom));
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   // a bound pair: usually an ordered window, sometimes any two values
   task automatic random_window(int top, output int lo, output int hi);
      if ($urandom_range(0, 5) == 0) begin
         lo = $urandom_range(0, 255);
         hi = $urandom_range(0, 255);
      end else begin
         lo = $urandom_range(0, top);
         hi = $urandom_range(lo, top);
      end
   endtask

   task automatic random_bounds();
      int hl, hh, sl, sh, vl, vh;
      random_window(($urandom_range(0, 7) == 0) ? 255 : HUE_TOP, hl, hh);
      random_window(255, sl, sh);
      random_window(255, vl, vh);
      set_bounds(hl, hh, sl, sh, vl, vh);
   endtask

   task automatic run_directed();
      send_pixel(make_pixel(0, 0, 0, 0));        // black
      send_pixel(make_pixel(255, 255, 255, 1));  // white
      send_pixel(make_pixel(128, 128, 128, 0));  // grey
      send_pixel(make_pixel(0, 0, 255, 1));      // pure red
      send_pixel(make_pixel(0, 255, 0, 0));      // pure green
      send_pixel(make_pixel(255, 0, 0, 0));      // pure blue
      send_pixel(make_pixel(0, 255, 255, 0));    // red and green tie
      send_pixel(make_pixel(255, 255, 0, 1));    // green and blue tie
      send_pixel(make_pixel(255, 0, 255, 0));    // red and blue tie
      send_pixel(make_pixel(1, 0, 255, 0));      // negative delta rounds to hue 0
      send_pixel(make_pixel(60, 0, 255, 0));     // wrap, larger step
      send_pixel(make_pixel(0, 1, 60, 0));       // hue lands on one half
      send_pixel(make_pixel(1, 1, 2, 1));        // saturation lands on one half
      send_pixel(make_pixel(0, 0, 1, 0));        // darkest color
      send_pixel(make_pixel(254, 1, 0, 0));
      send_pixel(make_pixel(100, 0, 60, 0));     // blue sector
      send_pixel(make_pixel(0, 100, 255, 1));
      send_pixel(make_pixel(200, 100, 50, 0));
      send_pixel(make_pixel(50, 150, 100, 0));
      send_pixel(make_pixel(70, 80, 90, 1));
      send_pixel(make_pixel(0, 70, 70, 0));      // edge of the default value bound
   endtask

   // bursts of random length with random gaps, now and then a full drain
   task automatic run_phase(int count);
      int sent;
      int burst;
      sent = 0;
      while (sent < count) begin
         burst = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 48) : $urandom_range(1, 12);
         for (int k = 0; k < burst && sent < count; k++) begin
            send_pixel(random_pixel());
            sent++;
         end
         if ($urandom_range(0, 29) == 0) hold_until_drained();
         else idle_cycles($urandom_range(0, 9));
      end
      hold_until_drained();
   endtask

   initial begin
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // reset bounds first
      run_directed();
      run_phase(FIXED_ITEMS);

      // everything passes
      set_bounds(0, HUE_TOP, 0, 255, 0, 255);
      run_phase(FIXED_ITEMS);
      // every low above its high
      set_bounds(255, 0, 255, 0, 255, 0);
      run_phase(FIXED_ITEMS);
      // only greys and black
      set_bounds(0, 0, 0, 0, 0, 255);
      run_phase(FIXED_ITEMS);
      // hue window at and past the top of the range
      set_bounds(HUE_TOP, 255, 0, 255, 1, 255);
      run_phase(FIXED_ITEMS);

      repeat (RAND_PHASES) begin
         random_bounds();
         run_phase(RAND_ITEMS);
      end

      hold_until_drained();
      if (sb.pending() != 0) $error("%0d results never arrived", sb.pending());
      if (sb.mismatches == 0 && sb.pending() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
